/* sv/rtp_pkg.sv */
package rtp_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned HALF_W  = 16;
  localparam int unsigned DUR_W   = 19;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned NUM_W   = 18;
  localparam int unsigned DEN_W   = 16;
  localparam int unsigned DLEN_W  = 8;
  localparam int unsigned DOCT_W  = 3;
  localparam int unsigned OCT_W   = 4;
  localparam int unsigned ACC_W   = 16;

  localparam logic [NUM_W-1:0]  MINUTE_MS    = NUM_W'(60000);
  localparam logic [DEN_W-1:0]  BPM_RESET    = DEN_W'(63);
  localparam logic [DLEN_W-1:0] DLEN_RESET   = DLEN_W'(4);
  localparam logic [DOCT_W-1:0] DOCT_RESET   = DOCT_W'(6);
  localparam logic [DLEN_W-1:0] DLEN_MAX     = DLEN_W'(255);
  localparam logic [ACC_W-1:0]  ACC_MAX      = ACC_W'(65535);

  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3a;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2c;
  localparam logic [CHAR_W-1:0] CH_SHARP = 8'h23;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2e;
  localparam logic [CHAR_W-1:0] CH_REST  = 8'h70;
  localparam logic [CHAR_W-1:0] CH_D     = 8'h64;
  localparam logic [CHAR_W-1:0] CH_O     = 8'h6f;
  localparam logic [CHAR_W-1:0] CH_B     = 8'h62;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_THREE = 8'h33;
  localparam logic [CHAR_W-1:0] CH_SEVEN = 8'h37;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  localparam logic [CHAR_W-1:0] CH_NOTE_C  = 8'h63;
  localparam logic [CHAR_W-1:0] CH_NOTE_D  = 8'h64;
  localparam logic [CHAR_W-1:0] CH_NOTE_E  = 8'h65;
  localparam logic [CHAR_W-1:0] CH_NOTE_F  = 8'h66;
  localparam logic [CHAR_W-1:0] CH_NOTE_G  = 8'h67;
  localparam logic [CHAR_W-1:0] CH_NOTE_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_NOTE_B  = 8'h62;
  localparam logic [CHAR_W-1:0] CH_NOTE_HC = 8'h43;

  localparam logic [HALF_W-1:0] PLAIN_TAB [8] = '{
    16'd1915, 16'd1700, 16'd1519, 16'd1432, 16'd1275, 16'd1136, 16'd1014, 16'd956
  };
  localparam logic [HALF_W-1:0] SHARP_TAB [8] = '{
    16'd1807, 16'd1605, 16'd0, 16'd1352, 16'd1203, 16'd1072, 16'd0, 16'd0
  };

  typedef enum logic [KIND_W-1:0] {
    KIND_TONE = 2'd0,
    KIND_REST = 2'd1,
    KIND_SKIP = 2'd2
  } kind_e;

  typedef struct packed {
    logic [HALF_W-1:0] half;
    kind_e             kind;
  } tone_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

  function automatic tone_t tone_lookup(logic [CHAR_W-1:0] letter, logic sharp,
                                        logic [OCT_W-1:0] oct);
    tone_t             t;
    logic [HALF_W-1:0] base;
    logic              hit;
    logic [2:0]        idx;
    hit = 1'b1;
    idx = 3'd0;
    unique case (letter)
      CH_NOTE_C:  idx = 3'd0;
      CH_NOTE_D:  idx = 3'd1;
      CH_NOTE_E:  idx = 3'd2;
      CH_NOTE_F:  idx = 3'd3;
      CH_NOTE_G:  idx = 3'd4;
      CH_NOTE_A:  idx = 3'd5;
      CH_NOTE_B:  idx = 3'd6;
      CH_NOTE_HC: idx = 3'd7;
      default:    hit = 1'b0;
    endcase
    base = sharp ? SHARP_TAB[idx] : PLAIN_TAB[idx];
    t.half = '0;
    t.kind = KIND_SKIP;
    if (letter == CH_REST) begin
      t.kind = KIND_REST;
    end else if (hit) begin
      if (base == '0) begin
        t.kind = KIND_REST;
      end else begin
        t.kind = KIND_TONE;
        if (oct >= OCT_W'(4)) begin
          t.half = base >> (oct - OCT_W'(4));
        end else begin
          t.half = base << (OCT_W'(4) - oct);
        end
      end
    end
    return t;
  endfunction

endpackage

/* sv/rtp_div.sv */
module rtp_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rtp_pkg::div_req_t req_i,
  output rtp_pkg::div_rsp_t rsp_o
);
  import rtp_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic [DEN_W:0]   trial;
  logic             fits;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial = {rem_q, quo_q[NUM_W-1]};
    fits  = trial >= {1'b0, den_q};
    rem_d = fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
    quo_d = {quo_q[NUM_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(NUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.num;
      den_q <= req_i.den;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.quot = quo_q;

endmodule

/* sv/rtttl_tune_parser.sv */
// RTTTL tune parser. Characters of the tune text arrive one per beat on the
// slave stream; tlast marks the final character, after which the parser returns
// to its reset state. Each note comes out as one beat once the character after it
// (normally its comma) or the final character arrives. The character that closes a
// note, and the one that closes the header, also waits for the shared restoring
// divider, which works one quotient bit per cycle. The input is not ready while
// a character is being worked on. The result sits in an output register, so a
// new character is taken while a note still waits on the master side; a note
// only stalls when the previous one has not been taken yet.
module rtttl_tune_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,      // enabled
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // char_code
  input  logic        s_axis_tlast,    // last_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,    // half_period_us[15:0], duration_ms[34:16], zero pad
  output logic [1:0]  m_axis_tuser,    // note_kind
  output logic        m_axis_tlast     // tune_end
);
  import rtp_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_FIN,
    S_WAIT
  } state_e;

  typedef enum logic [3:0] {
    PH_NAME, PH_DCHK, PH_DSKIP, PH_DNUM, PH_OCHK, PH_OSKIP, PH_ODIG, PH_OCOMMA,
    PH_BCHK, PH_BSKIP, PH_BNUM, PH_NCOUNT, PH_NSHARP, PH_NDOT, PH_NOCT, PH_NEND
  } phase_e;

  state_e            st_q;
  phase_e            phase_q;
  logic [CHAR_W-1:0] char_q;
  logic              last_q;
  logic              emitted_q;
  logic              cont_q;
  logic              fin_q;
  logic              emit_q;
  logic              enabled_q;
  logic [DLEN_W-1:0] dlen_q;
  logic [DOCT_W-1:0] doct_q;
  logic [DEN_W-1:0]  bpm_q;
  logic [NUM_W-1:0]  whole_q;
  logic [ACC_W-1:0]  acc_q;
  logic [CHAR_W-1:0] pl_q;
  logic              ps_q;
  logic              pd_q;
  logic [OCT_W-1:0]  po_q;
  logic              out_valid_q;
  logic [HALF_W-1:0] out_half_q;
  logic [DUR_W-1:0]  out_dur_q;
  kind_e             out_kind_q;
  logic              out_end_q;

  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic              in_acc;
  logic              is_digit;
  logic [19:0]       acc_wide;
  logic [ACC_W-1:0]  acc_next;
  logic [DEN_W-1:0]  bpm_src;
  logic [DEN_W-1:0]  count;
  logic              wn_go;
  logic              em_go;
  logic              div_done;
  logic              out_free;
  logic              do_reset;
  tone_t             tone;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (st_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign is_digit = (char_q >= CH_ZERO) && (char_q <= CH_NINE);
  assign acc_wide = {acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
                  + {12'd0, char_q - CH_ZERO};
  assign acc_next = (acc_wide > {4'd0, ACC_MAX}) ? ACC_MAX : acc_wide[ACC_W-1:0];

  assign bpm_src = (phase_q == PH_BNUM) ? acc_q : bpm_q;

  always_comb begin
    count = (acc_q != '0) ? acc_q : {{(ACC_W-DLEN_W){1'b0}}, dlen_q};
    if (count == '0) begin
      count = DEN_W'(1);
    end
  end

  assign wn_go = (st_q == S_STEP)
              && (((phase_q == PH_BCHK) && (char_q != CH_B))
               || ((phase_q == PH_BNUM) && !is_digit));
  assign em_go = ((st_q == S_STEP) && (phase_q == PH_NEND))
              || ((st_q == S_FIN) && last_q && !emitted_q && (phase_q >= PH_NSHARP));

  always_comb begin
    div_req.start = wn_go || em_go;
    div_req.num   = em_go ? whole_q : MINUTE_MS;
    div_req.den   = em_go ? count : ((bpm_src == '0) ? DEN_W'(1) : bpm_src);
  end

  rtp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign tone     = tone_lookup(pl_q, ps_q, po_q);
  assign out_free = !out_valid_q || m_axis_tready;
  assign div_done = (st_q == S_WAIT) && !div_rsp.busy;

  assign do_reset = (in_acc && !enabled_q && s_axis_tlast)
                 || ((st_q == S_FIN) && last_q && !em_go)
                 || (div_done && emit_q && fin_q && out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      phase_q     <= PH_NAME;
      last_q      <= 1'b0;
      emitted_q   <= 1'b0;
      cont_q      <= 1'b0;
      fin_q       <= 1'b0;
      emit_q      <= 1'b0;
      enabled_q   <= 1'b1;
      dlen_q      <= DLEN_RESET;
      doct_q      <= DOCT_RESET;
      bpm_q       <= BPM_RESET;
      whole_q     <= '0;
      acc_q       <= '0;
      pl_q        <= '0;
      ps_q        <= 1'b0;
      pd_q        <= 1'b0;
      po_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        enabled_q <= cfg_data_i;
      end
      if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      unique case (st_q)
        S_IDLE: begin
          if (in_acc && enabled_q) begin
            last_q    <= s_axis_tlast;
            emitted_q <= 1'b0;
            st_q      <= S_STEP;
          end
        end
        S_STEP: begin
          st_q <= S_FIN;
          unique case (phase_q)
            PH_NAME: begin
              if (char_q == CH_COLON) begin
                phase_q <= PH_DCHK;
              end
            end
            PH_DCHK: begin
              if (char_q == CH_D) begin
                phase_q <= PH_DSKIP;
              end else begin
                phase_q <= PH_OCHK;
                st_q    <= S_STEP;
              end
            end
            PH_DSKIP: begin
              acc_q   <= '0;
              phase_q <= PH_DNUM;
            end
            PH_DNUM: begin
              if (is_digit) begin
                acc_q <= acc_next;
              end else begin
                if (acc_q != '0) begin
                  dlen_q <= (acc_q > {8'd0, DLEN_MAX}) ? DLEN_MAX : acc_q[DLEN_W-1:0];
                end
                acc_q   <= '0;
                phase_q <= PH_OCHK;
              end
            end
            PH_OCHK: begin
              if (char_q == CH_O) begin
                phase_q <= PH_OSKIP;
              end else begin
                phase_q <= PH_BCHK;
                st_q    <= S_STEP;
              end
            end
            PH_OSKIP: phase_q <= PH_ODIG;
            PH_ODIG: begin
              if ((char_q >= CH_THREE) && (char_q <= CH_SEVEN)) begin
                doct_q <= char_q[DOCT_W-1:0];
              end
              phase_q <= PH_OCOMMA;
            end
            PH_OCOMMA: phase_q <= PH_BCHK;
            PH_BCHK: begin
              if (char_q == CH_B) begin
                phase_q <= PH_BSKIP;
              end else begin
                cont_q <= 1'b1;
                emit_q <= 1'b0;
                st_q   <= S_WAIT;
              end
            end
            PH_BSKIP: begin
              acc_q   <= '0;
              phase_q <= PH_BNUM;
            end
            PH_BNUM: begin
              if (is_digit) begin
                acc_q <= acc_next;
              end else begin
                bpm_q  <= acc_q;
                cont_q <= 1'b0;
                emit_q <= 1'b0;
                st_q   <= S_WAIT;
              end
            end
            PH_NCOUNT: begin
              if (is_digit) begin
                acc_q <= acc_next;
              end else begin
                pl_q    <= char_q;
                ps_q    <= 1'b0;
                pd_q    <= 1'b0;
                po_q    <= {1'b0, doct_q};
                phase_q <= PH_NSHARP;
              end
            end
            PH_NSHARP: begin
              phase_q <= PH_NDOT;
              if (char_q == CH_SHARP) begin
                ps_q <= 1'b1;
              end else begin
                st_q <= S_STEP;
              end
            end
            PH_NDOT: begin
              phase_q <= PH_NOCT;
              if (char_q == CH_DOT) begin
                pd_q <= 1'b1;
              end else begin
                st_q <= S_STEP;
              end
            end
            PH_NOCT: begin
              phase_q <= PH_NEND;
              if (is_digit) begin
                po_q <= char_q[OCT_W-1:0];
              end else begin
                st_q <= S_STEP;
              end
            end
            PH_NEND: begin
              fin_q  <= 1'b0;
              emit_q <= 1'b1;
              st_q   <= S_WAIT;
            end
          endcase
        end
        S_FIN: begin
          if (em_go) begin
            fin_q  <= 1'b1;
            emit_q <= 1'b1;
            st_q   <= S_WAIT;
          end else begin
            st_q <= S_IDLE;
          end
        end
        S_WAIT: begin
          if (div_done && !emit_q) begin
            whole_q <= {div_rsp.quot[NUM_W-3:0], 2'b00};
            acc_q   <= '0;
            phase_q <= PH_NCOUNT;
            st_q    <= cont_q ? S_STEP : S_FIN;
          end else if (div_done && out_free) begin
            out_valid_q <= 1'b1;
            acc_q       <= '0;
            emitted_q   <= 1'b1;
            phase_q     <= PH_NCOUNT;
            if (fin_q) begin
              st_q <= S_IDLE;
            end else if (char_q == CH_COMMA) begin
              st_q <= S_FIN;
            end else begin
              st_q <= S_STEP;
            end
          end
        end
        default: st_q <= S_IDLE;
      endcase

      if (do_reset) begin
        phase_q <= PH_NAME;
        dlen_q  <= DLEN_RESET;
        doct_q  <= DOCT_RESET;
        bpm_q   <= BPM_RESET;
        whole_q <= '0;
        acc_q   <= '0;
        pl_q    <= '0;
        ps_q    <= 1'b0;
        pd_q    <= 1'b0;
        po_q    <= '0;
        st_q    <= S_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      char_q <= s_axis_tdata;
    end
    if (div_done && emit_q && out_free) begin
      out_half_q <= tone.half;
      out_dur_q  <= pd_q ? {div_rsp.quot, 1'b0} : {1'b0, div_rsp.quot};
      out_kind_q <= tone.kind;
      out_end_q  <= last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_dur_q, out_half_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_end_q;

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import rtp_pkg::*;

  localparam int unsigned QUIET_LIMIT   = 3000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam logic [7:0]  CH_EQ         = 8'h3d;
  localparam logic [7:0]  CH_FILLER     = 8'h6e;

  localparam logic [7:0] NOTE_LETTERS [9] = '{
    CH_NOTE_C, CH_NOTE_D, CH_NOTE_E, CH_NOTE_F, CH_NOTE_G, CH_NOTE_A, CH_NOTE_B,
    CH_NOTE_HC, CH_REST
  };

  typedef enum logic [3:0] {
    SCAN_TITLE, SEEK_DLEN, DLEN_EQ, DLEN_NUM, SEEK_OCT, OCT_EQ, OCT_DIGIT, OCT_SEP,
    SEEK_BPM, BPM_EQ, BPM_NUM, NOTE_COUNT, NOTE_SHARP, NOTE_DOT, NOTE_OCT, NOTE_CLOSE
  } parse_state_e;

  typedef struct packed {
    logic [HALF_W-1:0] half;
    logic [DUR_W-1:0]  dur;
    kind_e             kind;
    logic              tune_end;
  } note_t;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } tune_char_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i    = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  rtttl_tune_parser i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // parser state as the block should hold it
  parse_state_e      tp_phase;
  logic [DLEN_W-1:0] tp_dlen;
  logic [DOCT_W-1:0] tp_doct;
  logic [DEN_W-1:0]  tp_bpm;
  logic [NUM_W-1:0]  tp_whole;
  logic [ACC_W-1:0]  tp_acc;
  logic [7:0]        tp_letter;
  logic              tp_sharp;
  logic              tp_dotted;
  logic [OCT_W-1:0]  tp_oct;
  logic              tp_enabled;

  tune_char_t  chars_pending[$];
  tune_char_t  draft[$];
  note_t       notes_due[$];
  tune_char_t  drv_char;
  note_t       drv_note;
  int unsigned chars_queued  = 0;
  int unsigned fail_count    = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  function automatic void clear_parser();
    tp_phase  = SCAN_TITLE;
    tp_dlen   = DLEN_RESET;
    tp_doct   = DOCT_RESET;
    tp_bpm    = BPM_RESET;
    tp_whole  = '0;
    tp_acc    = '0;
    tp_letter = '0;
    tp_sharp  = 1'b0;
    tp_dotted = 1'b0;
    tp_oct    = '0;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic void push_digit(logic [7:0] c);
    int unsigned v;
    v = 32'(tp_acc) * 10 + 32'(c - CH_ZERO);
    tp_acc = (v > 32'(ACC_MAX)) ? ACC_MAX : v[ACC_W-1:0];
  endfunction

  function automatic void begin_notes();
    int unsigned b;
    b = (tp_bpm == '0) ? 1 : 32'(tp_bpm);
    tp_whole = NUM_W'((32'(MINUTE_MS) / b) * 4);
    tp_acc = '0;
    tp_phase = NOTE_COUNT;
  endfunction

  function automatic int letter_slot(logic [7:0] c);
    case (c)
      CH_NOTE_C:  return 0;
      CH_NOTE_D:  return 1;
      CH_NOTE_E:  return 2;
      CH_NOTE_F:  return 3;
      CH_NOTE_G:  return 4;
      CH_NOTE_A:  return 5;
      CH_NOTE_B:  return 6;
      CH_NOTE_HC: return 7;
      default:    return -1;
    endcase
  endfunction

  function automatic note_t close_note();
    note_t       n;
    int unsigned count;
    int unsigned dur;
    int unsigned base;
    int          slot;
    count = (tp_acc != '0) ? 32'(tp_acc) : 32'(tp_dlen);
    if (count == 0) count = 1;
    dur = 32'(tp_whole) / count;
    if (tp_dotted) dur = dur << 1;
    n.half = '0;
    n.dur = dur[DUR_W-1:0];
    n.kind = KIND_SKIP;
    n.tune_end = 1'b0;
    slot = letter_slot(tp_letter);
    if (tp_letter == CH_REST) begin
      n.kind = KIND_REST;
    end else if (slot >= 0) begin
      base = tp_sharp ? 32'(SHARP_TAB[slot]) : 32'(PLAIN_TAB[slot]);
      if (base == 0) begin
        n.kind = KIND_REST;
      end else begin
        n.kind = KIND_TONE;
        if (tp_oct >= 4) n.half = HALF_W'(base >> (32'(tp_oct) - 4));
        else n.half = HALF_W'(base << (4 - 32'(tp_oct)));
      end
    end
    tp_acc = '0;
    return n;
  endfunction

  // one character through the parser; a character may fall through several states
  function automatic bit take_char(input logic [7:0] c, output note_t n);
    bit emitted;
    bit done;
    emitted = 1'b0;
    done = 1'b0;
    n = '0;
    while (!done) begin
      done = 1'b1;
      case (tp_phase)
        SCAN_TITLE: if (c == CH_COLON) tp_phase = SEEK_DLEN;
        SEEK_DLEN: begin
          if (c == CH_D) tp_phase = DLEN_EQ;
          else begin
            tp_phase = SEEK_OCT;
            done = 1'b0;
          end
        end
        DLEN_EQ: begin
          tp_acc = '0;
          tp_phase = DLEN_NUM;
        end
        DLEN_NUM: begin
          if (is_digit(c)) push_digit(c);
          else begin
            if (tp_acc != '0) tp_dlen = (tp_acc > ACC_W'(DLEN_MAX)) ? DLEN_MAX : tp_acc[7:0];
            tp_acc = '0;
            tp_phase = SEEK_OCT;
          end
        end
        SEEK_OCT: begin
          if (c == CH_O) tp_phase = OCT_EQ;
          else begin
            tp_phase = SEEK_BPM;
            done = 1'b0;
          end
        end
        OCT_EQ: tp_phase = OCT_DIGIT;
        OCT_DIGIT: begin
          if (c >= CH_THREE && c <= CH_SEVEN) tp_doct = DOCT_W'(c - CH_ZERO);
          tp_phase = OCT_SEP;
        end
        OCT_SEP: tp_phase = SEEK_BPM;
        SEEK_BPM: begin
          if (c == CH_B) tp_phase = BPM_EQ;
          else begin
            begin_notes();
            done = 1'b0;
          end
        end
        BPM_EQ: begin
          tp_acc = '0;
          tp_phase = BPM_NUM;
        end
        BPM_NUM: begin
          if (is_digit(c)) push_digit(c);
          else begin
            tp_bpm = tp_acc;
            begin_notes();
          end
        end
        NOTE_COUNT: begin
          if (is_digit(c)) push_digit(c);
          else begin
            tp_letter = c;
            tp_sharp = 1'b0;
            tp_dotted = 1'b0;
            tp_oct = {1'b0, tp_doct};
            tp_phase = NOTE_SHARP;
          end
        end
        NOTE_SHARP: begin
          tp_phase = NOTE_DOT;
          if (c == CH_SHARP) tp_sharp = 1'b1;
          else done = 1'b0;
        end
        NOTE_DOT: begin
          tp_phase = NOTE_OCT;
          if (c == CH_DOT) tp_dotted = 1'b1;
          else done = 1'b0;
        end
        NOTE_OCT: begin
          tp_phase = NOTE_CLOSE;
          if (is_digit(c)) tp_oct = OCT_W'(c - CH_ZERO);
          else done = 1'b0;
        end
        NOTE_CLOSE: begin
          n = close_note();
          emitted = 1'b1;
          tp_phase = NOTE_COUNT;
          if (c != CH_COMMA) done = 1'b0;
        end
      endcase
    end
    return emitted;
  endfunction

  function automatic bit predict_char(input logic [7:0] c, input logic last, output note_t n);
    bit got;
    got = 1'b0;
    n = '0;
    if (tp_enabled) begin
      got = take_char(c, n);
      if (last && !got && tp_phase >= NOTE_SHARP) begin
        n = close_note();
        got = 1'b1;
      end
      if (last && got) n.tune_end = 1'b1;
    end
    if (last) clear_parser();
    return got;
  endfunction

  function automatic void put(logic [7:0] c);
    tune_char_t t;
    t.code = c;
    t.last = 1'b0;
    draft.push_back(t);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endfunction

  function automatic void flush_draft();
    tune_char_t t;
    t = draft.pop_back();
    t.last = 1'b1;
    draft.push_back(t);
    foreach (draft[i]) chars_pending.push_back(draft[i]);
    chars_queued += draft.size();
    draft.delete();
  endfunction

  function automatic string count_text();
    case ($urandom_range(9))
      0:       return "0";
      1:       return $sformatf("%0d", $urandom_range(256, 9999999));
      2:       return $sformatf("%0d", $urandom_range(1, 255));
      default: return $sformatf("%0d", 1 << $urandom_range(5));
    endcase
  endfunction

  function automatic string bpm_text();
    case ($urandom_range(9))
      0:       return "0";
      1:       return $sformatf("%0d", $urandom_range(65536, 999999));
      default: return $sformatf("%0d", $urandom_range(25, 300));
    endcase
  endfunction

  function automatic void add_tune();
    int unsigned notes;
    int unsigned cut;
    logic [7:0]  c;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 15)) put(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(3)) begin
        c = $urandom_range(1) ? 8'($urandom_range(8'h61, 8'h7a)) : 8'($urandom_range(255));
        put(c == CH_COLON ? CH_FILLER : c);
      end
      put(CH_COLON);
      if ($urandom_range(3) != 0) begin
        put(CH_D);
        put(CH_EQ);
        put_text(count_text());
        put(CH_COMMA);
      end
      if ($urandom_range(3) != 0) begin
        put(CH_O);
        put(CH_EQ);
        put($urandom_range(7) == 0 ? 8'($urandom_range(255))
                                   : 8'($urandom_range(CH_THREE, CH_SEVEN)));
        put(CH_COMMA);
      end
      if ($urandom_range(3) != 0) begin
        put(CH_B);
        put(CH_EQ);
        put_text(bpm_text());
        put(CH_COLON);
      end
      notes = $urandom_range(1, 10);
      repeat (notes) begin
        if ($urandom_range(1)) put_text(count_text());
        case ($urandom_range(9))
          0:       put(8'($urandom_range(255)));
          1:       put(8'($urandom_range(8'h61, 8'h7a)));
          default: put(NOTE_LETTERS[$urandom_range(8)]);
        endcase
        if ($urandom_range(9) < 3) put(CH_SHARP);
        if ($urandom_range(3) == 0) put(CH_DOT);
        if ($urandom_range(9) < 6) begin
          put($urandom_range(3) != 0 ? 8'($urandom_range(8'h34, CH_SEVEN))
                                     : 8'($urandom_range(CH_ZERO, CH_NINE)));
        end
        if ($urandom_range(19) != 0) put(CH_COMMA);
      end
      if (draft[draft.size()-1].code == CH_COMMA && $urandom_range(1)) void'(draft.pop_back());
      if ($urandom_range(9) == 0) begin
        cut = $urandom_range(1, draft.size());
        while (draft.size() > cut) void'(draft.pop_back());
      end
    end
    flush_draft();
  endfunction

  task automatic settle();
    while (chars_pending.size() != 0 || s_axis_tvalid || notes_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_enable(input logic value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    tp_enabled = value;
    cfg_valid_i <= 1'b0;
  endtask

  // sender
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (predict_char(s_axis_tdata, s_axis_tlast, drv_note)) notes_due.push_back(drv_note);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (chars_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_char = chars_pending.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= drv_char.code;
          s_axis_tlast <= drv_char.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  function automatic void flag_field(string what, int unsigned want, int unsigned got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    fail_count++;
  endfunction

  // receiver and note checker
  always @(posedge clk_i) begin
    note_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (notes_due.size() == 0) begin
          $display("%0t: unexpected note beat, expected none, actual half=%0d dur=%0d kind=%0d end=%0b",
                   $time, m_axis_tdata[15:0], m_axis_tdata[34:16], m_axis_tuser, m_axis_tlast);
          fail_count++;
        end else begin
          want = notes_due.pop_front();
          if (m_axis_tdata[15:0] !== want.half) flag_field("half period", want.half, m_axis_tdata[15:0]);
          if (m_axis_tdata[34:16] !== want.dur) flag_field("duration", want.dur, m_axis_tdata[34:16]);
          if (m_axis_tuser !== want.kind) flag_field("note kind", want.kind, m_axis_tuser);
          if (m_axis_tlast !== want.tune_end) flag_field("tune end", want.tune_end, m_axis_tlast);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    tp_enabled = 1'b1;
    clear_parser();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 22;
    recv_idle_pct = 81;
    // zero length, bad octave, zero bpm, unmatched sharp, dotted rest, rest closed by the final character
    put_text(":d=0,o=9,b=0:e#.,9p");
    put(8'hff);
    flush_draft();
    // saturating bpm, missing comma, unknown letter, pending letter at end
    put(8'h00);
    put_text(":b=99999:c.7x,d");
    flush_draft();
    while (chars_queued < 420) add_tune();
    settle();

    write_enable(1'b0);
    repeat (4) add_tune();
    settle();
    write_enable(1'b1);

    send_idle_pct = 81;
    recv_idle_pct = 22;
    while (chars_queued < 650) add_tune();
    settle();
    while (chars_queued < 850) add_tune();
    settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (chars_queued < 1300) add_tune();
    settle();

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
